// ===== design/ovn_pkg.sv =====
`timescale 1ns / 1ps
// Package for the octave value noise block: command/status structs, state
// encoding, register indexes and the cosine easing weight table.
// No dependencies.
package ovn_pkg;

   // Easing table resolution and fixed arithmetic constants
   localparam int unsigned COS_TABLE_BITS = 8;
   localparam int unsigned WT_COUNT       = 1 << COS_TABLE_BITS;
   localparam logic [31:0] LCG_MUL        = 32'd1664525;
   localparam logic [31:0] LCG_INC        = 32'd1013904223;
   localparam logic [63:0] PI_Q30         = 64'd3373259426;
   localparam logic [63:0] ONE_Q30        = 64'd1 << 30;
   localparam logic [15:0] AMP_START      = 16'd32768;
   localparam logic [15:0] FALLOFF_RESET  = 16'd32768;
   localparam logic [3:0]  OCTAVES_RESET  = 4'd4;
   localparam int unsigned OCT_CNT_W      = 5;

   // Configuration register indexes
   localparam logic [1:0] CSR_OCTAVE_COUNT = 2'd0;
   localparam logic [1:0] CSR_FALLOFF      = 2'd1;

   // Request kinds
   localparam logic REQ_RESEED = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   // Weight selection for a blend step
   localparam logic [1:0] WSEL_X = 2'd0;
   localparam logic [1:0] WSEL_Y = 2'd1;
   localparam logic [1:0] WSEL_Z = 2'd2;

   typedef logic [16:0] wtab_type [WT_COUNT];

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEED,
      ST_READ,
      ST_BLEND,
      ST_ACCUM,
      ST_DONE_QUERY,
      ST_DONE_SEED
   } ctrl_state_type;

   typedef struct packed {
      logic       load;
      logic       seed_step;
      logic       rd_en;
      logic [2:0] rd_corner;
      logic       cap_en;
      logic       wt_latch;
      logic       blend_en;
      logic [2:0] blend_step;
      logic       accum_en;
      logic       out_load;
      logic       out_seed;
   } cmd_type;

   typedef struct packed {
      logic                 seed_last;
      logic                 out_free;
      logic [OCT_CNT_W-1:0] oct_total;
   } status_type;

   // Weight for the lower half: (1 - cos(pi*k/N))/2 in Q0.16, cosine by
   // a truncated Taylor series in Q2.30
   function automatic wtab_type build_wtab();
      wtab_type           t;
      logic [63:0]        theta;
      logic [63:0]        th2;
      logic [63:0]        term;
      logic signed [63:0] c;
      int unsigned        half;
      half = WT_COUNT >> 1;
      for (int unsigned k = 0; k < WT_COUNT; k++) begin
         t[k] = 17'd0;
      end
      for (int unsigned k = 0; k <= half && k < WT_COUNT; k++) begin
         theta = (PI_Q30 * 64'(k)) >> COS_TABLE_BITS;
         th2   = (theta * theta) >> 30;
         term  = ONE_Q30;
         c     = $signed(ONE_Q30);
         for (int unsigned i = 1; i <= 7; i++) begin
            term = (term * th2) >> 30;
            case (i)
               1: term = term / 64'd2;
               2: term = term / 64'd12;
               3: term = term / 64'd30;
               4: term = term / 64'd56;
               5: term = term / 64'd90;
               6: term = term / 64'd132;
               default: term = term / 64'd182;
            endcase
            if (i[0]) c = c - $signed(term);
            else c = c + $signed(term);
         end
         if (c < 0) c = 64'sd0;
         if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
         t[k] = 17'(((ONE_Q30 - 64'(c)) + 64'd16384) >> 15);
      end
      for (int unsigned k = half + 1; k < WT_COUNT; k++) begin
         t[k] = 17'(32'd65536 - 32'(t[WT_COUNT - k]));
      end
      return t;
   endfunction

   localparam wtab_type WTAB = build_wtab();

   function automatic logic [1:0] blend_wsel(input logic [2:0] step);
      logic [1:0] w;
      case (step)
         3'd0, 3'd1, 3'd2, 3'd3: w = WSEL_X;
         3'd4, 3'd5:             w = WSEL_Y;
         default:                w = WSEL_Z;
      endcase
      return w;
   endfunction

endpackage

// ===== design/ovn_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ovn_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/ovn_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer for the octave value noise block: reseed sweep, corner reads,
// blend steps and per-octave accumulation. Depends on ovn_pkg.
module ovn_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   input  logic               req_tuser,     // [0] request kind
   output logic               req_tready,
   output ovn_pkg::cmd_type    cmd,
   input  ovn_pkg::status_type status
);
   import ovn_pkg::*;

   ctrl_state_type       state_ff, state_in;
   logic [3:0]           step_ff, step_in;
   logic [OCT_CNT_W-1:0] oct_ff, oct_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= 4'd0;
         oct_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         oct_ff   <= oct_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      oct_in     = oct_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = 4'd0;
               oct_in   = '0;
               state_in = (req_tuser == REQ_RESEED) ? ST_SEED : ST_READ;
            end
         end
         ST_SEED: begin
            cmd.seed_step = 1'b1;
            if (status.seed_last) state_in = ST_DONE_SEED;
         end
         ST_READ: begin
            // issue one corner read a cycle, capture the previous one
            cmd.wt_latch  = (step_ff == 4'd0);
            cmd.rd_en     = (step_ff < 4'd8);
            cmd.rd_corner = step_ff[2:0];
            cmd.cap_en    = (step_ff != 4'd0);
            if (step_ff == 4'd8) begin
               step_in  = 4'd0;
               state_in = ST_BLEND;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_BLEND: begin
            cmd.blend_en   = 1'b1;
            cmd.blend_step = step_ff[2:0];
            if (step_ff == 4'd6) begin
               step_in  = 4'd0;
               state_in = ST_ACCUM;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         ST_ACCUM: begin
            cmd.accum_en = 1'b1;
            if (oct_ff + 1'b1 == status.oct_total) begin
               state_in = ST_DONE_QUERY;
            end else begin
               oct_in   = oct_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_DONE_QUERY: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_DONE_SEED: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_seed = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Never overwrite an unread result
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("result loaded while output slot busy");

   // An accepted item always leaves idle
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   // Octave counter stays below the configured total while working
   a_oct_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ || state_ff == ST_BLEND || state_ff == ST_ACCUM)
      |-> (oct_ff < status.oct_total))
      else $error("octave counter overran");

endmodule

// ===== design/ovn_datapath.sv =====
`timescale 1ns / 1ps
// Datapath for the octave value noise block: level table RAM, generator,
// coordinate registers, blend unit, accumulator and result register.
// Depends on ovn_pkg and ovn_ram.
module ovn_datapath #(
   parameter int TABLE_SIZE    = 4096,
   parameter int Y_STRIDE_BITS = 4,
   parameter int Z_STRIDE_BITS = 8,
   parameter int MAX_OCTAVES   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic [127:0]        req_tdata,
   input  ovn_pkg::cmd_type    cmd,
   output ovn_pkg::status_type status,
   input  logic                csr_valid,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [15:0]         rsp_tdata,
   output logic                rsp_tuser
);
   import ovn_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam int ACC_W  = 32 + $clog2(MAX_OCTAVES);
   localparam logic [ADDR_W-1:0] Y_OFF = ADDR_W'(64'd1 << Y_STRIDE_BITS);
   localparam logic [ADDR_W-1:0] Z_OFF = ADDR_W'(64'd1 << Z_STRIDE_BITS);

   // Configuration registers
   logic [3:0]  octave_ff;
   logic [15:0] falloff_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         octave_ff  <= OCTAVES_RESET;
         falloff_ff <= FALLOFF_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_OCTAVE_COUNT && csr_data[3:0] != 4'd0) begin
            octave_ff <= (32'(csr_data[3:0]) > MAX_OCTAVES) ?
                         4'(MAX_OCTAVES) : csr_data[3:0];
         end
         if (csr_index == CSR_FALLOFF && csr_data != 16'd0) begin
            falloff_ff <= csr_data;
         end
      end
   end

   assign status.oct_total = (32'(octave_ff) > MAX_OCTAVES) ?
                             OCT_CNT_W'(MAX_OCTAVES) : OCT_CNT_W'(octave_ff);

   // Generator and fill counter
   logic [31:0]       gen_ff;
   logic [31:0]       gen_next;
   logic [ADDR_W-1:0] fill_ff;

   assign gen_next = gen_ff * LCG_MUL + LCG_INC;
   assign status.seed_last = (fill_ff == {ADDR_W{1'b1}});

   always_ff @(posedge clock) begin
      if (reset) begin
         gen_ff  <= 32'd0;
         fill_ff <= '0;
      end else if (cmd.load) begin
         gen_ff  <= req_tdata[31:0];
         fill_ff <= '0;
      end else if (cmd.seed_step) begin
         gen_ff  <= gen_next;
         fill_ff <= fill_ff + 1'b1;
      end
   end

   // Absolute coordinates split into integer and fraction
   logic [31:0] abs_x, abs_y, abs_z;
   assign abs_x = req_tdata[63]  ? (~req_tdata[63:32] + 32'd1)  : req_tdata[63:32];
   assign abs_y = req_tdata[95]  ? (~req_tdata[95:64] + 32'd1)  : req_tdata[95:64];
   assign abs_z = req_tdata[127] ? (~req_tdata[127:96] + 32'd1) : req_tdata[127:96];

   logic [ADDR_W-1:0] xi_ff, yi_ff, zi_ff;
   logic [15:0]       xf_ff, yf_ff, zf_ff;
   logic [15:0]       amp_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [15:0]       v_ff [8];

   // Corner address: cell base plus stride offsets
   logic [ADDR_W-1:0] base;
   logic [ADDR_W-1:0] rd_addr;
   logic [15:0]       rd_data;

   assign base = xi_ff + ADDR_W'(yi_ff << Y_STRIDE_BITS) + ADDR_W'(zi_ff << Z_STRIDE_BITS);
   assign rd_addr = base + (cmd.rd_corner[0] ? ADDR_W'(1) : '0)
                         + (cmd.rd_corner[1] ? Y_OFF : '0)
                         + (cmd.rd_corner[2] ? Z_OFF : '0);

   ovn_ram #(
      .WIDTH(16),
      .DEPTH(TABLE_SIZE)
   ) u_level_ram (
      .clock  (clock),
      .wr_en  (cmd.seed_step),
      .wr_addr(fill_ff),
      .wr_data(gen_next[31:16]),
      .rd_en  (cmd.rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Easing weights, latched at the start of each octave
   logic [16:0] wx_ff, wy_ff, wz_ff;
   always_ff @(posedge clock) begin
      if (cmd.wt_latch) begin
         wx_ff <= WTAB[xf_ff[15 -: COS_TABLE_BITS]];
         wy_ff <= WTAB[yf_ff[15 -: COS_TABLE_BITS]];
         wz_ff <= WTAB[zf_ff[15 -: COS_TABLE_BITS]];
      end
   end

   // Blend unit: a + (b - a) * w, rounded, on the two head entries
   logic [16:0]        w_sel;
   logic signed [16:0] diff;
   logic signed [34:0] prod;
   logic signed [34:0] blend_sum;
   logic [15:0]        blend_res;

   always_comb begin
      case (blend_wsel(cmd.blend_step))
         WSEL_X:  w_sel = wx_ff;
         WSEL_Y:  w_sel = wy_ff;
         default: w_sel = wz_ff;
      endcase
   end

   assign diff      = $signed({1'b0, v_ff[1]}) - $signed({1'b0, v_ff[0]});
   assign prod      = 35'(diff) * 35'($signed({1'b0, w_sel}));
   assign blend_sum = $signed({3'b000, v_ff[0], 16'h0000}) + prod + 35'sd32768;
   assign blend_res = blend_sum[31:16];

   // Working queue: corners shift in at the tail; a blend pops two entries
   // off the head and appends the result behind what remains
   always_ff @(posedge clock) begin
      if (cmd.cap_en) begin
         for (int i = 0; i < 7; i++) begin
            v_ff[i] <= v_ff[i+1];
         end
         v_ff[7] <= rd_data;
      end else if (cmd.blend_en) begin
         for (int i = 0; i < 6; i++) begin
            if (i != 6 - int'(cmd.blend_step)) begin
               v_ff[i] <= v_ff[i+2];
            end
         end
         v_ff[3'd6 - cmd.blend_step] <= blend_res;
      end
   end

   // Octave accumulation, amplitude falloff and coordinate doubling
   logic [31:0] amp_prod;
   logic [31:0] wt_prod;
   assign amp_prod = 32'(amp_ff) * 32'(falloff_ff);
   assign wt_prod  = 32'(v_ff[0]) * 32'(amp_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         xi_ff  <= ADDR_W'(abs_x[31:16]);
         yi_ff  <= ADDR_W'(abs_y[31:16]);
         zi_ff  <= ADDR_W'(abs_z[31:16]);
         xf_ff  <= abs_x[15:0];
         yf_ff  <= abs_y[15:0];
         zf_ff  <= abs_z[15:0];
         amp_ff <= AMP_START;
         acc_ff <= '0;
      end else if (cmd.accum_en) begin
         acc_ff <= acc_ff + ACC_W'(wt_prod);
         amp_ff <= amp_prod[31:16];
         xi_ff  <= ADDR_W'({xi_ff, xf_ff[15]});
         yi_ff  <= ADDR_W'({yi_ff, yf_ff[15]});
         zi_ff  <= ADDR_W'({zi_ff, zf_ff[15]});
         xf_ff  <= {xf_ff[14:0], 1'b0};
         yf_ff  <= {yf_ff[14:0], 1'b0};
         zf_ff  <= {zf_ff[14:0], 1'b0};
      end
   end

   // Round and saturate the sum to Q0.16
   logic [ACC_W:0]  rounded;
   logic [15:0]     noise;
   assign rounded = {1'b0, acc_ff} + (ACC_W+1)'(32768);
   assign noise   = (rounded[ACC_W:32] != '0) ? 16'hFFFF : rounded[31:16];

   // Result register
   logic        rsp_valid_ff;
   logic [15:0] rsp_data_ff;
   logic        rsp_user_ff;

   assign status.out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= cmd.out_seed ? 16'd0 : noise;
         rsp_user_ff <= cmd.out_seed;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A reseed acknowledgement carries a zero level
   a_seed_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_user_ff) |-> (rsp_data_ff == 16'd0))
      else $error("reseed result with non-zero level");

   // The fill counter moves only during the reseed sweep or on a new item
   a_fill_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(cmd.seed_step) && !$past(cmd.load) && !$past(reset)) |-> $stable(fill_ff))
      else $error("fill counter moved outside a reseed");

endmodule

// ===== design/octave_value_noise_3d.sv =====
`timescale 1ns / 1ps
// Top level of the octave value noise block: sequencer plus datapath.
// Depends on ovn_pkg, ovn_ctrl, ovn_datapath and ovn_ram.
//
// Usage:
//   req_ channel: one item per request. tuser selects reseed (0) or query
//   (1). A reseed fills the level table from the seed by the linear
//   congruential generator; a query sums trilinear value noise over the
//   configured octaves for |x|, |y|, |z| in Q16.16.
//   rsp_ channel: one item per request, noise level in tdata, tuser set for
//   a reseed acknowledgement (tdata zero then).
//   csr_ channel: register writes, always ready; write only while idle.
//   Work: a query does, per octave, the corner reads on the single table
//   read port, seven blend steps on the shared blend unit and one
//   accumulate, then loads the result into the output register, raising
//   rsp_tvalid. A reseed fills the level table, one table write a cycle.
//   One item is worked on at a time; req_tready is high only while idle.
//   Reset clears the sequencer, the generator state, the result register and
//   the registers to four octaves and falloff one half. The table holds
//   nothing until the first reseed, and queries must follow one.
//   Stall: a finished result waits in the output register while a new item
//   may be accepted; that item's result waits until the slot is free.
module octave_value_noise_3d #(
   parameter int TABLE_SIZE    = 4096,
   parameter int Y_STRIDE_BITS = 4,
   parameter int Z_STRIDE_BITS = 8,
   parameter int MAX_OCTAVES   = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // seed_value, coord_x, coord_y, coord_z
   input  logic         req_tuser,   // req_type
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,   // noise_value
   output logic         rsp_tuser,   // reseed_done
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_data
);
   import ovn_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   ovn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tuser (req_tuser),
      .req_tready(req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   ovn_datapath #(
      .TABLE_SIZE   (TABLE_SIZE),
      .Y_STRIDE_BITS(Y_STRIDE_BITS),
      .Z_STRIDE_BITS(Z_STRIDE_BITS),
      .MAX_OCTAVES  (MAX_OCTAVES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .csr_valid (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tready(rsp_tready),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule
